// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Needs clk and rst_n in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define LMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LMT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lmt_pkg.sv -----
// Shared types and constants of the LCD mode timing and register block.
// No dependencies.
package lmt_pkg;

    localparam int ACC_W  = 12;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0] ADDR_LCDC = 8'h40;
    localparam logic [7:0] ADDR_STAT = 8'h41;
    localparam logic [7:0] ADDR_SCY  = 8'h42;
    localparam logic [7:0] ADDR_SCX  = 8'h43;
    localparam logic [7:0] ADDR_LY   = 8'h44;
    localparam logic [7:0] ADDR_LYC  = 8'h45;
    localparam logic [7:0] ADDR_BGP  = 8'h47;

    localparam logic [ACC_W-1:0] CYC_OAM    = 12'd80;
    localparam logic [ACC_W-1:0] CYC_XFER   = 12'd172;
    localparam logic [ACC_W-1:0] CYC_HBLANK = 12'd204;
    localparam logic [ACC_W-1:0] CYC_LINE   = 12'd456;

    localparam logic [7:0] LINE_VBLANK_START = 8'd144;
    localparam logic [7:0] LINE_FRAME_END    = 8'd153;

    // Timing state handed into the tick logic.
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        mode_t            mode;
        logic [7:0]       line;
        logic [7:0]       line_compare;
        logic [3:0]       stat_en;
        logic             match;
    } timing_state_t;

    // Timing state and pulses after one tick.
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        mode_t            mode;
        logic [7:0]       line;
        logic             match;
        logic             vblank_irq;
        logic             stat_irq;
        logic             line_done;
        logic             frame_done;
    } tick_result_t;

endpackage

// ----- rtl/lmt_timing.sv -----
// Tick logic: saturating cycle accumulate, one mode step, line and compare update.
// Depends on lmt_pkg.
module lmt_timing
    import lmt_pkg::*;
(
    input  timing_state_t    cur,
    input  logic [BYTE_W-1:0] elapsed_cycles,
    output tick_result_t     nxt
);

    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] acc_sat;
    logic [ACC_W-1:0] thr;
    logic             done;
    logic [ACC_W-1:0] acc_left;
    logic [7:0]       line_inc;

    assign sum      = {1'b0, cur.acc} + {{(ACC_W + 1 - BYTE_W){1'b0}}, elapsed_cycles};
    assign acc_sat  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    assign done     = (acc_sat >= thr);
    assign acc_left = acc_sat - thr;
    assign line_inc = cur.line + 8'd1;

    always_comb
    begin
        unique case (cur.mode)
            MODE_HBLANK: thr = CYC_HBLANK;
            MODE_VBLANK: thr = CYC_LINE;
            MODE_OAM:    thr = CYC_OAM;
            MODE_XFER:   thr = CYC_XFER;
            default:     thr = CYC_LINE;
        endcase
    end

    always_comb
    begin
        nxt.acc        = done ? acc_left : acc_sat;
        nxt.mode       = cur.mode;
        nxt.line       = cur.line;
        nxt.match      = cur.match;
        nxt.vblank_irq = 1'b0;
        nxt.stat_irq   = 1'b0;
        nxt.line_done  = 1'b0;
        nxt.frame_done = 1'b0;
        if (done)
        begin
            unique case (cur.mode)
                MODE_HBLANK:
                begin
                    nxt.line_done = 1'b1;
                    nxt.line      = line_inc;
                    if (line_inc == LINE_VBLANK_START)
                    begin
                        nxt.mode       = MODE_VBLANK;
                        nxt.vblank_irq = 1'b1;
                    end
                    else
                    begin
                        nxt.mode     = MODE_OAM;
                        nxt.stat_irq = cur.stat_en[2];
                    end
                end
                MODE_VBLANK:
                begin
                    nxt.line = line_inc;
                    if (line_inc == LINE_FRAME_END)
                    begin
                        nxt.line       = 8'd0;
                        nxt.mode       = MODE_OAM;
                        nxt.frame_done = 1'b1;
                    end
                end
                MODE_OAM:
                begin
                    nxt.mode = MODE_XFER;
                end
                MODE_XFER:
                begin
                    nxt.match    = (cur.line == cur.line_compare);
                    nxt.stat_irq = cur.stat_en[0]
                                   | ((cur.line == cur.line_compare) & cur.stat_en[3]);
                    nxt.mode     = MODE_HBLANK;
                end
                default:
                begin
                    nxt.mode = cur.mode;
                end
            endcase
        end
    end

endmodule

// ----- rtl/lcd_mode_timing_registers_unit.sv -----
// Top level of the LCD mode timing and register block.
// Depends on lmt_pkg and lmt_timing.
//
// Usage
//   Slave channel s_*: one word per tick, register write or register read.
//   s_tuser selects the kind (0 tick, 1 write, 2 read); s_tdata carries the
//   register address, the write byte and the elapsed cycle count.
//   Master channel m_*: exactly one result word per input word, in order,
//   with the read byte, the mode after the word and four pulse flags.
//   Path: an accepted word is held in the input register, worked on by the
//   decode and tick logic and lands in the result register when it advances,
//   from where its result is offered on the m_* channel.
//   Throughput: one word per clock unless m_* stalls; the state update is a
//   single add, compare and subtract between the input and result registers.
//   Stall: while the result register holds an untaken word, the word in the
//   input register waits and s_tready drops; when m_tready returns both
//   stages advance together, so no cycle is lost.
//   Reset: rst_n clears both valid flags, puts the mode in VBLANK and
//   clears the accumulator, line counter and all other block state registers.
module lcd_mode_timing_registers_unit
    import lmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // reg_addr[7:0], write_data[15:8], elapsed_cycles[23:16]
    input  logic [1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data[7:0], lcd_mode[9:8], vblank_irq[10],
                                  // stat_irq[11], line_done[12], frame_done[13], zero[15:14]
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_func_reg;
    logic [7:0]  in_addr_reg;
    logic [7:0]  in_data_reg;
    logic [7:0]  in_cyc_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg;

    // block state
    logic [ACC_W-1:0] acc_reg;
    mode_t            mode_reg;
    logic [7:0]       line_reg;
    logic [7:0]       lyc_reg;
    logic [7:0]       scy_reg;
    logic [7:0]       scx_reg;
    logic [7:0]       lcdc_reg;
    logic [3:0]       stat_en_reg;
    logic             match_reg;
    logic [7:0]       bgp_reg;

    logic             s_accept;
    logic             advance;
    logic             do_tick;
    logic             do_write;
    logic             do_read;
    logic [7:0]       rd_byte;
    timing_state_t    tcur;
    tick_result_t     tnxt;
    mode_t            mode_after;
    logic [15:0]      result;

    // Advance the item when the result register is empty or being drained.
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    assign do_tick  = advance & (in_func_reg == FUNC_TICK) & lcdc_reg[7];
    assign do_write = advance & (in_func_reg == FUNC_WRITE);
    assign do_read  = (in_func_reg == FUNC_READ);

    assign tcur.acc          = acc_reg;
    assign tcur.mode         = mode_reg;
    assign tcur.line         = line_reg;
    assign tcur.line_compare = lyc_reg;
    assign tcur.stat_en      = stat_en_reg;
    assign tcur.match        = match_reg;

    lmt_timing u_timing
    (
        .cur            (tcur),
        .elapsed_cycles (in_cyc_reg),
        .nxt            (tnxt)
    );

    // Register read mux; bg palette is write only.
    always_comb
    begin
        unique case (in_addr_reg)
            ADDR_LCDC: rd_byte = lcdc_reg;
            ADDR_STAT: rd_byte = {1'b0, stat_en_reg, match_reg, mode_reg};
            ADDR_SCY:  rd_byte = scy_reg;
            ADDR_SCX:  rd_byte = scx_reg;
            ADDR_LY:   rd_byte = line_reg;
            ADDR_LYC:  rd_byte = lyc_reg;
            default:   rd_byte = 8'd0;
        endcase
    end

    assign mode_after = do_tick ? tnxt.mode : mode_reg;

    always_comb
    begin
        result        = 16'd0;
        result[7:0]   = do_read ? rd_byte : 8'd0;
        result[9:8]   = mode_after;
        result[10]    = do_tick & tnxt.vblank_irq;
        result[11]    = do_tick & tnxt.stat_irq;
        result[12]    = do_tick & tnxt.line_done;
        result[13]    = do_tick & tnxt.frame_done;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load the input word on accept, the result on advance.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg <= s_tuser;
            in_addr_reg <= s_tdata[7:0];
            in_data_reg <= s_tdata[15:8];
            in_cyc_reg  <= s_tdata[23:16];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // Block state: update in the cycle the word leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            mode_reg    <= MODE_VBLANK;
            line_reg    <= 8'd0;
            lyc_reg     <= 8'd0;
            scy_reg     <= 8'd0;
            scx_reg     <= 8'd0;
            lcdc_reg    <= 8'd0;
            stat_en_reg <= 4'd0;
            match_reg   <= 1'b0;
            bgp_reg     <= 8'd0;
        end
        else if (do_tick)
        begin
            acc_reg   <= tnxt.acc;
            mode_reg  <= tnxt.mode;
            line_reg  <= tnxt.line;
            match_reg <= tnxt.match;
        end
        else if (do_write)
        begin
            unique case (in_addr_reg)
                ADDR_LCDC: lcdc_reg    <= in_data_reg;
                ADDR_STAT: stat_en_reg <= in_data_reg[6:3];
                ADDR_SCY:  scy_reg     <= in_data_reg;
                ADDR_SCX:  scx_reg     <= in_data_reg;
                ADDR_LYC:  lyc_reg     <= in_data_reg;
                ADDR_BGP:  bgp_reg     <= in_data_reg;
                default:   bgp_reg     <= bgp_reg;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- rtl/lmt_checker.sv -----
// Port-level checks of the LCD mode timing and register block, bound to the top.
// Depends on lmt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lmt_checker
    import lmt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `LMT_ASSERT_RST(a_no_word_in_reset, !rst_n |-> !m_tvalid, "result word offered during reset")
    `LMT_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result word changed")
    `LMT_ASSERT(a_vblank_entry, m_tvalid && m_tdata[10] |-> m_tdata[12] && m_tdata[9:8] == MODE_VBLANK, "vblank pulse without hblank end into vblank")
    `LMT_ASSERT(a_frame_wrap, m_tvalid && m_tdata[13] |-> m_tdata[9:8] == MODE_OAM && !m_tdata[12], "frame end not into oam search")
    `LMT_ASSERT(a_read_no_pulse, m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tdata[13:10] == 4'd0, "read word carries timing pulses")

endmodule

bind lcd_mode_timing_registers_unit lmt_checker u_lmt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/testbench.sv -----
// Self-checking bench for the LCD mode timing and register block.
// Depends on lmt_pkg and lcd_mode_timing_registers_unit; drives the word streams and
// compares every result word with an in-bench model of the timing and register state.
module testbench;
    import lmt_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;   // unused kind, must do nothing
    localparam logic [7:0] ADDR_DMA  = 8'h46;  // OAM DMA trigger, not decoded here
    localparam int ACC_SAT  = (1 << ACC_W) - 1;
    localparam int IDLE_MAX = 1000;             // cycles with no handshake before giving up
    localparam int LONG_HOLD = 90;              // one long receiver hold-off

    // One bus word as the sender sees it; drain makes the sender wait until
    // every earlier result word has come back before offering this one.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] addr;
        logic [7:0] wdata;
        logic [7:0] cycles;
        logic       drain;
    } bus_op_t;

    // One result word, fields in the order of m_tdata from the top down.
    typedef struct packed {
        logic       frame_done;
        logic       line_done;
        logic       stat_irq;
        logic       vblank_irq;
        mode_t      mode;
        logic [7:0] read_data;
    } lcd_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // reg_addr[7:0], write_data[15:8], elapsed_cycles[23:16]
    logic [1:0]  s_tuser = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // read_data[7:0], lcd_mode[9:8], vblank_irq[10],
                                 // stat_irq[11], line_done[12], frame_done[13], zero[15:14]

    // Shadow of the block's timing and register state.
    logic [ACC_W-1:0] lcd_acc;
    mode_t            lcd_mode;
    logic [7:0]       lcd_line;
    logic [7:0]       lcd_lyc;
    logic [7:0]       lcd_scy;
    logic [7:0]       lcd_scx;
    logic [7:0]       lcd_ctrl;
    logic [3:0]       lcd_stat_en;
    logic             lcd_match;
    logic [7:0]       lcd_bgp;

    bus_op_t     bus_ops[$];       // words still to be offered
    lcd_status_t awaited[$];       // predicted result words, oldest first
    bus_op_t     cur_op;
    int          burst_left;
    int          gap_left;
    int          words_accepted = 0;
    int          results_seen = 0;
    int          failures = 0;
    int          idle_cycles = 0;
    int          rx_cycle;
    int          hold_left;
    logic        hold_done;
    logic        rx_ready;

    // Tallies of what the run went through, taken from the predictions.
    int          n_reads = 0;
    int          n_writes = 0;
    int          n_ticks = 0;
    int          n_lines = 0;
    int          n_frames = 0;
    int          n_vblanks = 0;
    int          n_stat = 0;

    lcd_mode_timing_registers_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the shadow state by one word and return the result word it causes.
    function automatic lcd_status_t lcd_advance(bus_op_t op);
        lcd_status_t r;
        logic [ACC_W:0] sum;
        r = '0;
        case (op.func)
            FUNC_WRITE:
            begin
                // Line counter, DMA and unmapped addresses fall through untouched.
                case (op.addr)
                    ADDR_LCDC: lcd_ctrl = op.wdata;
                    ADDR_STAT: lcd_stat_en = op.wdata[6:3];
                    ADDR_SCY:  lcd_scy = op.wdata;
                    ADDR_SCX:  lcd_scx = op.wdata;
                    ADDR_LYC:  lcd_lyc = op.wdata;
                    ADDR_BGP:  lcd_bgp = op.wdata;
                    default: ;
                endcase
            end
            FUNC_READ:
            begin
                case (op.addr)
                    ADDR_LCDC: r.read_data = lcd_ctrl;
                    ADDR_STAT: r.read_data = {1'b0, lcd_stat_en, lcd_match, lcd_mode};
                    ADDR_SCY:  r.read_data = lcd_scy;
                    ADDR_SCX:  r.read_data = lcd_scx;
                    ADDR_LY:   r.read_data = lcd_line;
                    ADDR_LYC:  r.read_data = lcd_lyc;
                    default:   r.read_data = '0;
                endcase
            end
            FUNC_TICK:
            begin
                if (lcd_ctrl[7])
                begin
                    sum = {1'b0, lcd_acc} + op.cycles;
                    if (sum > ACC_SAT)
                        sum = (ACC_W + 1)'(ACC_SAT);
                    // At most one mode change per tick.
                    case (lcd_mode)
                        MODE_HBLANK:
                        begin
                            if (sum >= CYC_HBLANK)
                            begin
                                sum = sum - CYC_HBLANK;
                                r.line_done = 1'b1;
                                lcd_line = lcd_line + 8'd1;
                                if (lcd_line == LINE_VBLANK_START)
                                begin
                                    lcd_mode = MODE_VBLANK;
                                    r.vblank_irq = 1'b1;
                                end
                                else
                                begin
                                    r.stat_irq = lcd_stat_en[2];
                                    lcd_mode = MODE_OAM;
                                end
                            end
                        end
                        MODE_VBLANK:
                        begin
                            if (sum >= CYC_LINE)
                            begin
                                sum = sum - CYC_LINE;
                                lcd_line = lcd_line + 8'd1;
                                if (lcd_line == LINE_FRAME_END)
                                begin
                                    lcd_line = '0;
                                    lcd_mode = MODE_OAM;
                                    r.frame_done = 1'b1;
                                end
                            end
                        end
                        MODE_OAM:
                        begin
                            if (sum >= CYC_OAM)
                            begin
                                sum = sum - CYC_OAM;
                                lcd_mode = MODE_XFER;
                            end
                        end
                        default:
                        begin
                            if (sum >= CYC_XFER)
                            begin
                                sum = sum - CYC_XFER;
                                r.stat_irq = lcd_stat_en[0];
                                lcd_match = (lcd_line == lcd_lyc);
                                if (lcd_match && lcd_stat_en[3])
                                    r.stat_irq = 1'b1;
                                lcd_mode = MODE_HBLANK;
                            end
                        end
                    endcase
                    lcd_acc = sum[ACC_W-1:0];
                end
            end
            default: ;
        endcase
        r.mode = lcd_mode;
        return r;
    endfunction

    task automatic queue_op(input logic [1:0] func, input logic [7:0] addr,
                            input logic [7:0] wdata, input logic [7:0] cycles,
                            input logic drain);
        bus_ops.push_back('{func: func, addr: addr, wdata: wdata, cycles: cycles,
                            drain: drain});
    endtask

    // Driver: predict each accepted word, then offer the next one in bursts
    // with random gaps. Drive valid once per edge from the decision below.
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        logic        take;
        logic        give;
        lcd_status_t st;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left = 1;
            gap_left = 0;
            lcd_acc = '0;
            lcd_mode = MODE_VBLANK;
            lcd_line = '0;
            lcd_lyc = '0;
            lcd_scy = '0;
            lcd_scx = '0;
            lcd_ctrl = '0;
            lcd_stat_en = '0;
            lcd_match = 1'b0;
            lcd_bgp = '0;
        end
        else
        begin
            take = s_tvalid && s_tready;
            if (take)
            begin
                st = lcd_advance(cur_op);
                awaited.push_back(st);
                words_accepted <= words_accepted + 1;
                n_reads += (cur_op.func == FUNC_READ);
                n_writes += (cur_op.func == FUNC_WRITE);
                n_ticks += (cur_op.func == FUNC_TICK);
                n_lines += st.line_done;
                n_frames += st.frame_done;
                n_vblanks += st.vblank_irq;
                n_stat += st.stat_irq;
            end
            if (take || !s_tvalid)
            begin
                give = 1'b0;
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                // A drain word waits until nothing is in flight.
                else if (bus_ops.size() != 0 &&
                         (!bus_ops[0].drain || (!take && results_seen == words_accepted)))
                begin
                    cur_op = bus_ops.pop_front();
                    give = 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        // Now and then a long burst with no gap at all.
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(20, 60);
                            gap_left = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left = $urandom_range(1, 12);
                        end
                    end
                end
                s_tvalid <= give;
                if (give)
                begin
                    s_tdata <= {cur_op.cycles, cur_op.wdata, cur_op.addr};
                    s_tuser <= cur_op.func;
                end
            end
        end
    end

    // Receiver stall pattern: four modes picked by rx_cycle[9:8], plus one long
    // hold-off once the run is well under way, so the block fills up and drops s_tready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            rx_cycle = rx_cycle + 1;
            if (!hold_done && words_accepted >= 150)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rx_ready = 1'b0;
            end
            else
            begin
                case (rx_cycle[9:8])
                    2'd0: rx_ready = 1'b1;
                    2'd1: rx_ready = ($urandom_range(0, 3) != 0);
                    2'd2: rx_ready = rx_cycle[0];
                    default: rx_ready = ($urandom_range(0, 9) < 4);
                endcase
            end
            m_tready <= rx_ready;
        end
    end

    // Monitor: check every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin : check_words
        lcd_status_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (awaited.size() == 0)
            begin
                $error("result word %0h with no prediction waiting", m_tdata);
                failures++;
            end
            else
            begin
                exp = awaited.pop_front();
                if (m_tdata[7:0] !== exp.read_data)
                begin
                    $error("read_data: expected %0h, got %0h", exp.read_data, m_tdata[7:0]);
                    failures++;
                end
                if (m_tdata[9:8] !== exp.mode)
                begin
                    $error("lcd_mode: expected %0d, got %0d", exp.mode, m_tdata[9:8]);
                    failures++;
                end
                if (m_tdata[10] !== exp.vblank_irq)
                begin
                    $error("vblank_irq: expected %0b, got %0b", exp.vblank_irq, m_tdata[10]);
                    failures++;
                end
                if (m_tdata[11] !== exp.stat_irq)
                begin
                    $error("stat_irq: expected %0b, got %0b", exp.stat_irq, m_tdata[11]);
                    failures++;
                end
                if (m_tdata[12] !== exp.line_done)
                begin
                    $error("line_done: expected %0b, got %0b", exp.line_done, m_tdata[12]);
                    failures++;
                end
                if (m_tdata[13] !== exp.frame_done)
                begin
                    $error("frame_done: expected %0b, got %0b", exp.frame_done, m_tdata[13]);
                    failures++;
                end
                if (m_tdata[15:14] !== 2'b00)
                begin
                    $error("pad: expected 0, got %0h", m_tdata[15:14]);
                    failures++;
                end
            end
        end
    end

    // Watchdog: give up when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_MAX)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed words first, then tick-heavy random traffic fed a few
    // words ahead of the driver, on the falling edge.
    initial
    begin : stimulus
        bus_op_t op;
        int      n;
        int      pick;
        // Drop reset with an edge so every register with a reset clears before the first clock.
        rst_n <= 1'b0;
        // Register file corners with the display still off.
        queue_op(FUNC_READ,  ADDR_STAT, 8'h00, 8'h00, 1'b0);
        queue_op(FUNC_TICK,  8'h00,     8'h00, 8'hFF, 1'b0);  // disabled tick: no change
        queue_op(FUNC_NONE,  8'hFF,     8'hFF, 8'hFF, 1'b0);  // unused kind
        queue_op(FUNC_WRITE, ADDR_LY,   8'hFF, 8'h00, 1'b0);  // line counter is read only
        queue_op(FUNC_READ,  ADDR_LY,   8'h00, 8'h00, 1'b0);
        queue_op(FUNC_WRITE, ADDR_DMA,  8'hAA, 8'h00, 1'b0);  // DMA address ignored
        queue_op(FUNC_READ,  ADDR_DMA,  8'h00, 8'h00, 1'b0);
        queue_op(FUNC_WRITE, 8'hFF,     8'h5A, 8'h00, 1'b0);  // unmapped write
        queue_op(FUNC_READ,  8'h00,     8'h00, 8'h00, 1'b0);  // unmapped read
        queue_op(FUNC_WRITE, ADDR_STAT, 8'hFF, 8'h00, 1'b0);  // only enables stick
        queue_op(FUNC_READ,  ADDR_STAT, 8'h00, 8'h00, 1'b0);
        queue_op(FUNC_WRITE, ADDR_BGP,  8'hE4, 8'h00, 1'b0);
        queue_op(FUNC_READ,  ADDR_BGP,  8'h00, 8'h00, 1'b0);  // palette reads back zero
        queue_op(FUNC_WRITE, ADDR_SCY,  8'hA5, 8'h00, 1'b0);
        queue_op(FUNC_WRITE, ADDR_SCX,  8'hFF, 8'h00, 1'b0);
        queue_op(FUNC_READ,  ADDR_SCY,  8'h00, 8'h00, 1'b0);
        queue_op(FUNC_READ,  ADDR_SCX,  8'h00, 8'h00, 1'b0);
        queue_op(FUNC_WRITE, ADDR_LYC,  8'h01, 8'h00, 1'b0);
        queue_op(FUNC_READ,  ADDR_LYC,  8'h00, 8'h00, 1'b0);
        // Enable the display and start the timing.
        queue_op(FUNC_WRITE, ADDR_LCDC, 8'h91, 8'h00, 1'b0);
        queue_op(FUNC_READ,  ADDR_LCDC, 8'h00, 8'h00, 1'b0);
        queue_op(FUNC_TICK,  8'h00,     8'h00, 8'h00, 1'b0);
        queue_op(FUNC_TICK,  8'h00,     8'h00, 8'hFF, 1'b0);
        queue_op(FUNC_TICK,  8'h00,     8'h00, 8'hFF, 1'b0);
        queue_op(FUNC_READ,  ADDR_STAT, 8'h00, 8'h00, 1'b1);  // after a full drain

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Random part: at least the planned count, and on until the display has wrapped a
        // frame twice and entered vblank from the visible lines, up to 4000 words.
        for (n = 0; n < 4000 && (n < 650 || n_frames < 2 || n_vblanks < 1); n++)
        begin
            while (bus_ops.size() > 4)
                @(negedge clk);
            op.addr = $urandom_range(0, 255);
            op.wdata = $urandom_range(0, 255);
            op.cycles = $urandom_range(0, 255);
            op.drain = (n == 250 || n == 500);
            pick = $urandom_range(0, 99);
            if (!lcd_ctrl[7] && $urandom_range(0, 3) == 0)
            begin
                // Turn the display back on so the timing keeps moving.
                op.func = FUNC_WRITE;
                op.addr = ADDR_LCDC;
                op.wdata[7] = 1'b1;
            end
            else if (pick < 80)
            begin
                op.func = FUNC_TICK;
                // Mostly large steps so the accumulator saturates and lines roll.
                case ($urandom_range(0, 9))
                    0: op.cycles = $urandom_range(0, 16);
                    1, 2: op.cycles = $urandom_range(0, 255);
                    default: op.cycles = $urandom_range(200, 255);
                endcase
            end
            else if (pick < 88)
            begin
                op.func = FUNC_WRITE;
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        op.addr = ADDR_LCDC;
                        if ($urandom_range(0, 9) != 0)
                            op.wdata[7] = 1'b1;
                    end
                    2: op.addr = ADDR_STAT;
                    3: op.addr = ADDR_SCY;
                    4: op.addr = ADDR_SCX;
                    5: op.addr = ADDR_LY;
                    6, 7:
                    begin
                        // Aim the compare near the current line to hit matches.
                        op.addr = ADDR_LYC;
                        if ($urandom_range(0, 1) == 0)
                            op.wdata = lcd_line + 8'($urandom_range(0, 3));
                    end
                    8: op.addr = ($urandom_range(0, 1) == 0) ? ADDR_BGP : ADDR_DMA;
                    default: ;
                endcase
            end
            else if (pick < 97)
            begin
                op.func = FUNC_READ;
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    op.addr = ADDR_LCDC + 8'(pick);
            end
            else
                op.func = FUNC_NONE;
            bus_ops.push_back(op);
        end

        // Wait until every word has been taken and answered, then a few more.
        while (bus_ops.size() != 0 || s_tvalid || results_seen != words_accepted)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (awaited.size() != 0)
        begin
            $error("%0d predicted result words never arrived", awaited.size());
            failures++;
        end

        $display("tb: %0d words (%0d ticks, %0d writes, %0d reads), %0d failures",
                 words_accepted, n_ticks, n_writes, n_reads, failures);
        $display("tb: %0d lines done, %0d frames, %0d vblank entries, %0d status requests",
                 n_lines, n_frames, n_vblanks, n_stat);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lmt_pkg.sv
rtl/lmt_timing.sv
rtl/lcd_mode_timing_registers_unit.sv
rtl/lmt_checker.sv
tb/sv/testbench.sv
